// File: design/rct_pkg.sv
// Package for the three-channel root counter timer.
// Holds command codes, register offsets, mode bit positions and the
// controller/datapath command and status types. No dependencies.
package rct_pkg;

  localparam int unsigned NumTimers = 3;
  localparam int unsigned TickW     = 8;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_HB_ENTER = 3'd3,
    CMD_HB_LEAVE = 3'd4,
    CMD_VB_ENTER = 3'd5,
    CMD_VB_LEAVE = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_t;

  localparam logic [3:0] OFF_COUNT  = 4'd0;
  localparam logic [3:0] OFF_MODE   = 4'd4;
  localparam logic [3:0] OFF_TARGET = 4'd8;

  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  localparam int unsigned BitWrap    = 3;
  localparam int unsigned BitSrc0    = 8;
  localparam int unsigned BitSrc1    = 9;
  localparam int unsigned BitIrqOff  = 10;
  localparam int unsigned BitReached = 11;
  localparam int unsigned BitOvf     = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_TIMER,
    ST_WRAP,
    ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       capture;   // latch the accepted item
    logic       exec;      // perform the execute part of an item (bus, blank, prescaler)
    logic       load;      // load the tick amount of the selected timer
    logic       step;      // one advance step on the selected timer
    logic       wrap_step; // one restoring step of the target modulo, or its write-back
    logic [1:0] timer;     // timer under work for tick items
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_tick;    // captured item is a system tick
    logic more;       // selected timer still has ticks to apply
    logic need_wrap;  // current step needs a modulo by target + 1
    logic wrap_done;  // modulo steps finished
  } sts_t;

endpackage

// File: design/three_channel_root_counter_timer_unit.sv
// Top level of the three-channel root counter timer.
// Instantiates rct_ctrl and rct_dp; depends on rct_pkg.
//
// Channel | Direction | Fields (tdata, lowest bit first)
// in_     | slave     | cmd[2:0] access_width[4:3] reg_address[10:5]
//         |           | write_data[26:11] tick_count[34:27], zero fill to 40
// out_    | master    | read_data[15:0] read_valid[16], zero fill to 24
//
// Bus and blank items execute in the cycle after their transfer in; the result
// is offered from the next cycle. A tick item runs the prescaler, then for each
// timer a load, its advance steps (split where the count passes 0xFFFF) and a
// closing check, with a modulo by target + 1 after each step that takes a
// wrapping timer past its target; the result is then offered.
// Reset is synchronous and active low; all timers restart running at zero.
// A stalled result is held and the next item is taken in the same cycle
// the result transfers out.
module three_channel_root_counter_timer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, access_width, reg_address, write_data, tick_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data, read_valid
);
  import rct_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_fire, out_fire;
  logic [15:0] rd;
  logic        rv;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  rct_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .ctl,
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  rct_dp u_dp (
    .clk, .rst_n, .ctl,
    .cmd(in_tdata[2:0]), .access_width(in_tdata[4:3]), .reg_address(in_tdata[10:5]),
    .write_data(in_tdata[26:11]), .tick_count(in_tdata[34:27]),
    .sts, .read_data(rd), .read_valid(rv)
  );

  assign out_tdata = {7'd0, rv, rd};

  a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> !out_tvalid || in_tready == 1'b0) else $error("result repeated");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && !out_tvalid) |=> !out_tvalid || $past(in_fire) == 1'b0)
    else $error("result without item");
  a_rv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[16]) |-> out_tdata[15:0] == '0) else $error("stray read data");
endmodule

// File: design/rct_ctrl.sv
// Controller state machine of the root counter timer.
// Depends on rct_pkg for state, command and status types.
module rct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_fire,
  input  rct_pkg::sts_t sts,
  output rct_pkg::ctl_t ctl,
  output logic          in_ready,
  output logic          out_valid
);
  import rct_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] timer_r, timer_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        timer_nxt = 2'd0;
        state_nxt = sts.is_tick ? ST_LOAD : ST_OUT;
      end
      ST_LOAD: state_nxt = ST_TIMER;
      ST_TIMER: begin
        if (sts.more) begin
          if (sts.need_wrap) state_nxt = ST_WRAP;
        end else if (timer_r == 2'd2) begin
          state_nxt = ST_OUT;
        end else begin
          timer_nxt = timer_r + 2'd1;
          state_nxt = ST_LOAD;
        end
      end
      ST_WRAP: begin
        if (sts.wrap_done) state_nxt = ST_TIMER;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = in_fire ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.timer     = timer_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_fire;
      end
      ST_EXEC:  ctl.exec = 1'b1;
      ST_LOAD:  ctl.load = 1'b1;
      ST_TIMER: ctl.step = sts.more;
      ST_WRAP:  ctl.wrap_step = 1'b1;
      ST_OUT: begin
        out_valid   = 1'b1;
        in_ready    = out_fire;
        ctl.capture = in_fire;
      end
      default: ;
    endcase
  end

  a_wrap_from_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRAP && $past(state_r) != ST_WRAP) |-> $past(state_r) == ST_TIMER)
    else $error("modulo entered from wrong state");
  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r != 2'd3) else $error("timer index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fire) |=> out_valid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.capture, ctl.exec, ctl.load, ctl.step, ctl.wrap_step}))
    else $error("conflicting datapath commands");
endmodule

// File: design/rct_dp.sv
// Datapath of the root counter timer: timer state, bus access, blank sync,
// tick advance and a shift-and-subtract modulo unit. Depends on rct_pkg.
module rct_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rct_pkg::ctl_t             ctl,
  input  logic [2:0]                cmd,
  input  logic [1:0]                access_width,
  input  logic [5:0]                reg_address,
  input  logic [15:0]               write_data,
  input  logic [rct_pkg::TickW-1:0] tick_count,
  output rct_pkg::sts_t             sts,
  output logic [15:0]               read_data,
  output logic                      read_valid
);
  import rct_pkg::*;

  logic [15:0] count_r  [NumTimers];
  logic [12:0] mode_r   [NumTimers];
  logic [15:0] target_r [NumTimers];
  logic [NumTimers-1:0] run_r;
  logic [2:0]  pre_r;
  logic        hb_r, vb_r;

  logic [2:0]  cmd_r;
  logic [1:0]  width_r;
  logic [5:0]  addr_r;
  logic [15:0] wdata_r;
  logic [TickW-1:0] left_r;   // ticks still to apply to current timer
  logic [TickW-1:0] tick_r;
  logic [TickW-1:0] over8_r;
  logic [15:0] rd_r;
  logic        rv_r;

  // Modulo unit: remainder of a 17-bit value by target + 1, one bit per cycle.
  logic [16:0] rem_r;
  logic [32:0] dsh_r;
  logic [4:0]  wcnt_r;

  logic [1:0] n;
  logic [3:0] off;
  logic       mapped;
  assign n      = addr_r[5:4];
  assign off    = addr_r[3:0];
  assign mapped = (width_r == WIDTH_HALF || width_r == WIDTH_WORD) && n != 2'd3 &&
                  (off == OFF_COUNT || off == OFF_MODE || off == OFF_TARGET);

  // Amount of ticks assigned to timer tn by the tick item.
  function automatic logic [TickW-1:0] src_amt(input logic [1:0] tn, input logic [12:0] m,
                                               input logic [TickW-1:0] tk,
                                               input logic [TickW-1:0] o8);
    logic [TickW-1:0] a;
    a = tk;
    if (tn == 2'd2) begin
      if (m[BitSrc1]) a = o8;
    end else if (m[BitSrc0]) begin
      a = '0;
    end
    return a;
  endfunction

  logic [1:0]  t;
  logic [15:0] cur, tgt;
  logic [12:0] md;
  logic [16:0] edge_d, left_x, amt, sum;
  logic        crosses;
  assign t        = ctl.timer;
  assign cur      = count_r[t];
  assign tgt      = target_r[t];
  assign md       = mode_r[t];
  // A step never goes past 65536, so an advance splits at the overflow point.
  assign edge_d   = 17'h10000 - {1'b0, cur};
  assign left_x   = {{(17-TickW){1'b0}}, left_r};
  assign amt      = (left_x < edge_d) ? left_x : edge_d;
  assign sum      = {1'b0, cur} + amt;
  assign crosses  = sum > {1'b0, tgt} && cur <= tgt;

  assign sts.is_tick   = cmd_r == CMD_TICK;
  assign sts.more      = left_r != '0;
  assign sts.need_wrap = crosses && md[BitWrap];
  assign sts.wrap_done = wcnt_r == 5'd0;

  assign read_data  = rd_r;
  assign read_valid = rv_r;

  // Blank sync helper result.
  function automatic logic [1:0] blank_fx(input logic [12:0] m, input logic act,
                                          input logic run);
    // returns {clear_count, new_run}
    logic c, r;
    c = 1'b0;
    r = run;
    if (m[0]) begin
      case (m[2:1])
        2'd0: r = ~act;
        2'd1: c = act;
        2'd2: begin r = act; c = act; end
        default: if (act) r = 1'b1;
      endcase
    end
    return {c, r};
  endfunction

  always_ff @(posedge clk) begin
    logic [12:0] nm;
    logic [1:0]  bf;
    logic [8:0]  psum;
    logic        nr;
    logic        blk;
    logic        hz;
    if (!rst_n) begin
      for (int i = 0; i < NumTimers; i++) begin
        count_r[i]  <= '0;
        mode_r[i]   <= '0;
        target_r[i] <= '0;
      end
      run_r   <= '1;
      pre_r   <= '0;
      hb_r    <= 1'b0;
      vb_r    <= 1'b0;
      cmd_r   <= '0;
      width_r <= '0;
      addr_r  <= '0;
      wdata_r <= '0;
      tick_r  <= '0;
      over8_r <= '0;
      left_r  <= '0;
      rd_r    <= '0;
      rv_r    <= 1'b0;
      rem_r   <= '0;
      dsh_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      if (ctl.capture) begin
        cmd_r   <= cmd;
        width_r <= access_width;
        addr_r  <= reg_address;
        wdata_r <= write_data;
        tick_r  <= tick_count;
        rd_r    <= '0;
        rv_r    <= 1'b0;
      end
      if (ctl.exec) begin
        case (cmd_r)
          CMD_READ: if (mapped) begin
            rv_r <= 1'b1;
            case (off)
              OFF_COUNT: rd_r <= count_r[n];
              OFF_MODE: begin
                rd_r <= {3'd0, mode_r[n]};
                mode_r[n] <= mode_r[n] & ~13'h1800;
              end
              default: rd_r <= target_r[n];
            endcase
          end
          CMD_WRITE: if (mapped) begin
            case (off)
              OFF_COUNT: count_r[n] <= wdata_r;
              OFF_MODE: begin
                nm  = (mode_r[n] & 13'h1800) | {3'd0, wdata_r[9:0]} | 13'h0400;
                blk = (n == 2'd0) ? hb_r : vb_r;
                nr  = 1'b1;
                if (nm[0]) begin
                  if (n != 2'd2) begin
                    case (nm[2:1])
                      2'd0: nr = ~blk;
                      2'd2: nr = blk;
                      2'd3: nr = 1'b0;
                      default: ;
                    endcase
                  end else if (nm[2:1] == 2'd0 || nm[2:1] == 2'd3) begin
                    nr = 1'b0;
                  end
                end
                mode_r[n]  <= nm;
                count_r[n] <= '0;
                run_r[n]   <= nr;
              end
              default: target_r[n] <= wdata_r;
            endcase
          end
          CMD_TICK: begin
            // Timer 2 may count every eighth system clock.
            psum    = {6'd0, pre_r} + {1'b0, tick_r};
            pre_r   <= psum[2:0];
            over8_r <= TickW'(psum[8:3]);
          end
          CMD_HB_ENTER, CMD_HB_LEAVE: begin
            hb_r <= cmd_r == CMD_HB_ENTER;
            bf = blank_fx(mode_r[0], cmd_r == CMD_HB_ENTER, run_r[0]);
            run_r[0] <= bf[0];
            if (bf[1]) count_r[0] <= '0;
            // Hblank entry clocks a running timer 1 once when hblank is its source.
            if (cmd_r == CMD_HB_ENTER && mode_r[1][BitSrc0] && run_r[1]) begin
              nm = mode_r[1];
              hz = count_r[1] == target_r[1] && mode_r[1][BitWrap];
              if (count_r[1] == target_r[1]) nm[BitReached] = 1'b1;
              if (!hz && count_r[1] == 16'hffff) nm[BitOvf] = 1'b1;
              count_r[1] <= hz ? 16'd0 : count_r[1] + 16'd1;
              mode_r[1]  <= nm;
            end
          end
          CMD_VB_ENTER, CMD_VB_LEAVE: begin
            vb_r <= cmd_r == CMD_VB_ENTER;
            bf = blank_fx(mode_r[1], cmd_r == CMD_VB_ENTER, run_r[1]);
            run_r[1] <= bf[0];
            if (bf[1]) count_r[1] <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.load) begin
        // A stopped timer has nothing to apply for the whole item.
        left_r <= run_r[t] ? src_amt(t, mode_r[t], tick_r, over8_r) : '0;
      end
      if (ctl.step) begin
        nm = md;
        if (crosses) nm[BitReached] = 1'b1;
        if (crosses && md[BitWrap]) begin
          rem_r  <= sum;
          dsh_r  <= {({1'b0, tgt} + 17'd1), 16'd0};
          wcnt_r <= 5'd17;
        end else begin
          if (sum[16]) nm[BitOvf] = 1'b1;
          count_r[t] <= sum[15:0];
        end
        mode_r[t] <= nm;
        left_r    <= left_r - amt[TickW-1:0];
      end
      if (ctl.wrap_step) begin
        if (wcnt_r != 5'd0) begin
          if (dsh_r <= {16'd0, rem_r}) rem_r <= rem_r - dsh_r[16:0];
          dsh_r  <= dsh_r >> 1;
          wcnt_r <= wcnt_r - 5'd1;
        end else begin
          // The remainder is below target + 1, so it always fits 16 bits.
          count_r[t] <= rem_r[15:0];
        end
      end
    end
  end

  a_rv_data: assert property (@(posedge clk) disable iff (!rst_n)
    !rv_r |-> rd_r == '0) else $error("read data stray");
  a_wrap_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wrap_step && wcnt_r != 5'd0) |-> dsh_r != '0) else $error("modulo by zero");
  a_wrap_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wrap_step && wcnt_r == 5'd0) |-> rem_r < 17'h10000) else $error("remainder too wide");
  a_step_amt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> (amt != '0 && amt <= 17'h10000)) else $error("step out of range");
endmodule
